// File: src/ikc_pkg.sv
`timescale 1ns / 1ps
package ikc_pkg;

    // Default geometry limits
    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_KERNEL     = 7;
    localparam int DEF_CHANNELS       = 3;
    localparam int DEF_COEF_FRAC_BITS = 12;

    // Fixed field widths
    localparam int PIX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int RES_W     = 32;
    localparam int IO_CH     = 3;
    localparam int DIM_W     = 12;
    localparam int KDIM_W    = 3;
    localparam int CHN_W     = 2;
    localparam int CMD_W     = 2;
    localparam int CIDX_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int MAX_ROWS  = 4095;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_USED = 3'd4;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_COEF  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    // Control from the sequencer to the MAC datapath
    typedef struct packed {
        logic clr;
        logic valid;
    } t_mac_ctrl;

    typedef logic signed [RES_W-1:0] t_res;

endpackage

// File: src/ikc_line_mem.sv
`timescale 1ns / 1ps
module ikc_line_mem import ikc_pkg::*; #(
    parameter int DEPTH  = 7 * 2048,
    parameter int AW     = 14,
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ikc_coef_mem.sv
`timescale 1ns / 1ps
module ikc_coef_mem import ikc_pkg::*; #(
    parameter int DEPTH = 49,
    parameter int AW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [COEF_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [COEF_W-1:0] o_rdata
);

    logic signed [COEF_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;
    logic signed [COEF_W-1:0] r_rdata;
    logic                     r_rvld;

    // Write coefficient storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// File: src/ikc_mac.sv
`timescale 1ns / 1ps
module ikc_mac import ikc_pkg::*; #(
    parameter int MAX_KERNEL     = DEF_MAX_KERNEL,
    parameter int CHANNELS       = DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctrl                 i_ctrl,
    input  logic [CHANNELS*PIX_W-1:0] i_pix,
    input  logic signed [COEF_W-1:0]  i_coef,
    output t_res                      o_res [IO_CH]
);

    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(KK + 1) + 1;
    localparam int HALF   = (1 << COEF_FRAC_BITS) >> 1;
    localparam int NL     = (CHANNELS < IO_CH) ? CHANNELS : IO_CH;

    logic r_pv;

    // Product valid follows the memory data valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctrl.valid;
        end
    end

    genvar c;
    generate
        for (c = 0; c < IO_CH; c++) begin : g_lane
            if (c < NL) begin : g_act
                logic signed [PROD_W-1:0] r_prod;
                logic signed [ACC_W-1:0]  r_acc;
                logic signed [ACC_W-1:0]  rnd;
                logic signed [ACC_W-1:0]  q;
                logic                     fits;
                t_res                     r_res;

                // Multiply coefficient by sample
                always_ff @(posedge i_clk) begin
                    r_prod <= PROD_W'(i_coef * $signed({1'b0, i_pix[c*PIX_W +: PIX_W]}));
                end

                // Accumulate window products
                always_ff @(posedge i_clk) begin
                    if (i_ctrl.clr) begin
                        r_acc <= '0;
                    end else if (r_pv) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                end

                // Round half up, drop fraction, saturate
                always_comb begin
                    rnd  = r_acc + ACC_W'(HALF);
                    q    = rnd >>> COEF_FRAC_BITS;
                    fits = (&q[ACC_W-1:RES_W-1]) | ~(|q[ACC_W-1:RES_W-1]);
                end

                always_ff @(posedge i_clk) begin
                    if (fits) begin
                        r_res <= q[RES_W-1:0];
                    end else if (q[ACC_W-1]) begin
                        r_res <= {1'b1, {(RES_W-1){1'b0}}};
                    end else begin
                        r_res <= {1'b0, {(RES_W-1){1'b1}}};
                    end
                end

                assign o_res[c] = r_res;
            end else begin : g_off
                assign o_res[c] = '0;
            end
        end
    endgenerate

endmodule

// File: src/image_kernel_convolution_core.sv
`timescale 1ns / 1ps
// 2-D kernel correlation over a raster pixel stream with up to three channels.
// Input channel (i_in_valid / o_in_stall): each transaction carries a command:
// load one Q3.12 coefficient, push one pixel, or flush one pending result.
// Output channel (o_out_valid / i_out_stall): one filtered or passed-through
// pixel per transaction, in raster order, o_frame_last on the frame's final
// pixel. Results lag the pixel stream by half a kernel in rows and columns;
// flush transactions drain the remaining results at frame end.
// Configuration port (i_cfg_valid / o_cfg_ready) is always ready; write it
// only while the block is idle.
// A coefficient load, or a pixel that yields no result, is taken in the idle
// state. A border result passes its own line-store entry through. An interior
// result takes one line-store read per kernel tap, all channels in parallel,
// through a single registered memory port, then the multiply, accumulate and
// rounding stages.
// The finished result sits in an output register; a stalled receiver holds
// it, and the next input transaction is taken as soon as the core is idle.
// Reset restores the default geometry (640x480, 3x3 kernel, one channel),
// zeroes all coefficients and empties the pipe; no memory clearing pass.
module image_kernel_convolution_core import ikc_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL     = DEF_MAX_KERNEL,
    parameter int CHANNELS       = DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [CIDX_W-1:0]        i_coef_index,
    input  logic signed [COEF_W-1:0] i_coef_value,
    input  logic [PIX_W-1:0]         i_pix_c0,
    input  logic [PIX_W-1:0]         i_pix_c1,
    input  logic [PIX_W-1:0]         i_pix_c2,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [RES_W-1:0]  o_out_c0,
    output logic signed [RES_W-1:0]  o_out_c1,
    output logic signed [RES_W-1:0]  o_out_c2,
    output logic                     o_frame_last,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int SW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int AW     = SW + CW;
    localparam int DEPTH  = MAX_KERNEL * (2 ** CW);
    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int CIW    = (KK > 1) ? $clog2(KK) : 1;
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int PW     = $clog2((MAX_KERNEL / 2) * MAX_ROWS + MAX_KERNEL + 2);
    localparam int DATA_W = CHANNELS * PIX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [DIM_W-1:0]  r_img_w;
    logic [DIM_W-1:0]  r_img_h;
    logic [KDIM_W-1:0] r_ker_w;
    logic [KDIM_W-1:0] r_ker_h;
    logic [CHN_W-1:0]  r_chan;

    // Raster position state
    logic [DIM_W-1:0] r_in_col;
    logic [DIM_W-1:0] r_in_row;
    logic [SW-1:0]    r_in_slot;
    logic [DIM_W-1:0] r_out_col;
    logic [DIM_W-1:0] r_out_row;
    logic [SW-1:0]    r_out_slot;
    logic [PW-1:0]    r_pending;

    // Window sequencer
    logic             r_inner;
    logic [SW-1:0]    r_rslot;
    logic [DIM_W-1:0] r_col0;
    logic [KW-1:0]    r_i;
    logic [KW-1:0]    r_j;
    logic [CIW-1:0]   r_cbase;
    logic [1:0]       r_drain;
    logic             r_iss;

    // Output register
    logic             r_out_valid;
    t_res             r_out [IO_CH];
    logic             r_frame_last;

    // Effective geometry
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [KW-1:0]    kw;
    logic [KW-1:0]    kh;
    logic [KW-1:0]    wk;
    logic [KW-1:0]    hk;
    logic [2:0]       ch;
    logic [PW-1:0]    lag;
    logic             inner;

    logic             in_acc;
    t_cmd             cmd;
    logic [DIM_W-1:0] in_col_eff;
    logic [DIM_W-1:0] in_col_nxt;
    logic [PW-1:0]    pend_inc;
    logic [SW:0]      slot_sum;
    logic [SW-1:0]    slot_start;
    logic             out_free;

    logic              lm_we;
    logic [AW-1:0]     lm_waddr;
    logic [DATA_W-1:0] lm_wdata;
    logic [AW-1:0]     lm_raddr;
    logic [DATA_W-1:0] lm_rdata;

    logic                     cm_we;
    logic signed [COEF_W-1:0] cm_rdata;

    t_mac_ctrl mac_ctrl;
    t_res      mac_res [IO_CH];
    logic [PIX_W-1:0] pix_in [IO_CH];

    // Clamp registers to their usable ranges
    always_comb begin
        if (r_img_w == '0) begin
            w = DIM_W'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = r_img_w;
        end
        h = (r_img_h == '0) ? DIM_W'(1) : r_img_h;
        if (r_ker_w == '0) begin
            kw = KW'(1);
        end else if (32'(r_ker_w) > MAX_KERNEL) begin
            kw = KW'(MAX_KERNEL);
        end else begin
            kw = KW'(r_ker_w);
        end
        if (r_ker_h == '0) begin
            kh = KW'(1);
        end else if (32'(r_ker_h) > MAX_KERNEL) begin
            kh = KW'(MAX_KERNEL);
        end else begin
            kh = KW'(r_ker_h);
        end
        if (r_chan == '0) begin
            ch = 3'd1;
        end else if (32'(r_chan) > CHANNELS) begin
            ch = 3'(CHANNELS);
        end else begin
            ch = 3'(r_chan);
        end
        wk  = kw >> 1;
        hk  = kh >> 1;
        lag = PW'(PW'(hk) * PW'(w)) + PW'(wk);
        inner = (r_out_col >= DIM_W'(wk))
             && ((13'(r_out_col) + 13'(wk)) < 13'(w))
             && (r_out_row >= DIM_W'(hk))
             && ((13'(r_out_row) + 13'(hk)) < 13'(h));
    end

    // Input handshake and pixel write position
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cmd        = t_cmd'(i_cmd);
    assign in_col_eff = (r_in_col >= w) ? '0 : r_in_col;
    assign in_col_nxt = in_col_eff + DIM_W'(1);
    assign pend_inc   = r_pending + PW'(1);
    assign out_free   = !r_out_valid || !i_out_stall;

    // First window row slot: half a kernel above the output row
    always_comb begin
        slot_sum = {1'b0, r_out_slot} + (SW+1)'(MAX_KERNEL) - (SW+1)'(hk);
        if (32'(slot_sum) >= MAX_KERNEL) begin
            slot_start = SW'(32'(slot_sum) - MAX_KERNEL);
        end else begin
            slot_start = slot_sum[SW-1:0];
        end
    end

    // Line store access
    assign pix_in[0] = i_pix_c0;
    assign pix_in[1] = i_pix_c1;
    assign pix_in[2] = i_pix_c2;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            lm_wdata[c*PIX_W +: PIX_W] = (c < IO_CH) ? pix_in[c] : '0;
        end
    end

    assign lm_we    = in_acc && (cmd == CMD_PIXEL);
    assign lm_waddr = {r_in_slot, CW'(in_col_eff)};
    assign lm_raddr = (r_state == S_ISSUE) ? {r_rslot, CW'(r_col0 + DIM_W'(r_j))}
                                           : {r_out_slot, CW'(r_out_col)};

    ikc_line_mem #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .DATA_W (DATA_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (lm_we),
        .i_waddr (lm_waddr),
        .i_wdata (lm_wdata),
        .i_raddr (lm_raddr),
        .o_rdata (lm_rdata)
    );

    // Coefficient table
    assign cm_we = in_acc && (cmd == CMD_COEF) && (32'(i_coef_index) < KK);

    ikc_coef_mem #(
        .DEPTH (KK),
        .AW    (CIW)
    ) u_coef_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (cm_we),
        .i_waddr (CIW'(i_coef_index)),
        .i_wdata (i_coef_value),
        .i_raddr (CIW'(r_cbase + CIW'(r_j))),
        .o_rdata (cm_rdata)
    );

    // MAC datapath
    assign mac_ctrl.clr   = (r_state == S_SETUP);
    assign mac_ctrl.valid = r_iss;

    ikc_mac #(
        .MAX_KERNEL     (MAX_KERNEL),
        .CHANNELS       (CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_pix   (lm_rdata),
        .i_coef  (cm_rdata),
        .o_res   (mac_res)
    );

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= DIM_W'(640);
            r_img_h <= DIM_W'(480);
            r_ker_w <= KDIM_W'(3);
            r_ker_h <= KDIM_W'(3);
            r_chan  <= CHN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[DIM_W-1:0];
                REG_KERNEL_WIDTH:  r_ker_w <= i_cfg_data[KDIM_W-1:0];
                REG_KERNEL_HEIGHT: r_ker_h <= i_cfg_data[KDIM_W-1:0];
                REG_CHANNELS_USED: r_chan  <= i_cfg_data[CHN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: state, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            r_pending   <= '0;
            r_iss       <= 1'b0;
            r_out_valid <= 1'b0;
            r_inner     <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_drain     <= '0;
        end else begin
            r_iss <= (r_state == S_ISSUE);
            // Drop the output once it is taken
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (cmd == CMD_PIXEL) begin
                            // Advance the write position
                            if (in_col_nxt >= w) begin
                                r_in_col  <= '0;
                                r_in_slot <= (32'(r_in_slot) == MAX_KERNEL - 1) ? '0
                                             : r_in_slot + SW'(1);
                                r_in_row  <= (r_in_row + DIM_W'(1) >= h) ? '0
                                             : r_in_row + DIM_W'(1);
                            end else begin
                                r_in_col <= in_col_nxt;
                            end
                            r_pending <= pend_inc;
                            if (pend_inc > lag) begin
                                r_state <= S_SETUP;
                            end
                        end else if (cmd == CMD_FLUSH) begin
                            if (r_pending != '0) begin
                                r_state <= S_SETUP;
                            end
                        end
                    end
                end
                S_SETUP: begin
                    // Border pixels read their own entry this cycle
                    r_inner <= inner;
                    r_rslot <= slot_start;
                    r_col0  <= r_out_col - DIM_W'(wk);
                    r_i     <= '0;
                    r_j     <= '0;
                    r_cbase <= '0;
                    r_state <= inner ? S_ISSUE : S_EMIT;
                end
                S_ISSUE: begin
                    // Walk the window one tap per cycle
                    if (r_j == kw - KW'(1)) begin
                        r_j     <= '0;
                        r_i     <= r_i + KW'(1);
                        r_rslot <= (32'(r_rslot) == MAX_KERNEL - 1) ? '0
                                   : r_rslot + SW'(1);
                        r_cbase <= CIW'(r_cbase + CIW'(MAX_KERNEL));
                        if (r_i == kh - KW'(1)) begin
                            r_drain <= '0;
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_j <= r_j + KW'(1);
                    end
                end
                S_DRAIN: begin
                    // Wait for multiply, accumulate and rounding stages
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd2) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        for (int c = 0; c < IO_CH; c++) begin
                            if (c < CHANNELS && 3'(c) < ch) begin
                                r_out[c] <= r_inner ? mac_res[c]
                                    : RES_W'({1'b0, lm_rdata[c*PIX_W +: PIX_W]});
                            end else begin
                                r_out[c] <= '0;
                            end
                        end
                        r_frame_last <= (r_out_col + DIM_W'(1) >= w)
                                     && (r_out_row + DIM_W'(1) >= h);
                        r_out_valid  <= 1'b1;
                        if (r_pending != '0) begin
                            r_pending <= r_pending - PW'(1);
                        end
                        // Advance the read position
                        if (r_out_col + DIM_W'(1) >= w) begin
                            r_out_col  <= '0;
                            r_out_slot <= (32'(r_out_slot) == MAX_KERNEL - 1) ? '0
                                          : r_out_slot + SW'(1);
                            r_out_row  <= (r_out_row + DIM_W'(1) >= h) ? '0
                                          : r_out_row + DIM_W'(1);
                        end else begin
                            r_out_col <= r_out_col + DIM_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_c0     = r_out[0];
    assign o_out_c1     = r_out[1];
    assign o_out_c2     = r_out[2];
    assign o_frame_last = r_frame_last;

endmodule

// File: tb/image_kernel_convolution_core_tb.sv
`timescale 1ns / 1ps
module image_kernel_convolution_core_tb;
    import ikc_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXK = DEF_MAX_KERNEL;
    localparam int NCH = DEF_CHANNELS;
    localparam int FRAC = DEF_COEF_FRAC_BITS;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int MAX_GAP = 18;
    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic signed [RES_W-1:0] c0;
        logic signed [RES_W-1:0] c1;
        logic signed [RES_W-1:0] c2;
        logic                    last;
    } t_pixel_result;

    // Model of the filter: coefficient table, line slots, raster counters
    class conv_scoreboard;
        logic signed [COEF_W-1:0] coef[MAXK*MAXK];
        bit [PIX_W-1:0] lines[MAXK][MAXW][NCH];
        int unsigned in_col, in_row, out_col, out_row, in_slot, out_slot, pending;
        int unsigned reg_w, reg_h, reg_kw, reg_kh, reg_ch;
        t_pixel_result expected_pixels[$];
        int errors;

        function new();
            foreach (coef[i]) coef[i] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            in_slot = 0; out_slot = 0; pending = 0;
            reg_w = 640; reg_h = 480; reg_kw = 3; reg_kh = 3; reg_ch = 1;
            errors = 0;
        endfunction

        function int unsigned fit(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:   reg_w = 32'(data);
                REG_IMAGE_HEIGHT:  reg_h = 32'(data);
                REG_KERNEL_WIDTH:  reg_kw = 32'(data[KDIM_W-1:0]);
                REG_KERNEL_HEIGHT: reg_kh = 32'(data[KDIM_W-1:0]);
                REG_CHANNELS_USED: reg_ch = 32'(data[CHN_W-1:0]);
                default: ;
            endcase
        endfunction

        // Round half up, drop the fraction bits, saturate to 32 bits
        function logic signed [RES_W-1:0] rescale(longint s);
            longint q;
            s += (longint'(1) <<< FRAC) >>> 1;
            if (s >= 0) q = s >>> FRAC;
            else q = -((-s + (longint'(1) <<< FRAC) - 1) >>> FRAC);
            if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
            if (q < -64'sh8000_0000) q = -64'sh8000_0000;
            return q[RES_W-1:0];
        endfunction

        function void produce();
            int unsigned w, h, kw, kh, ch, wk, hk, x, y, slot;
            bit interior;
            longint acc;
            logic signed [RES_W-1:0] val[3];
            t_pixel_result r;
            w = fit(reg_w, MAXW); h = fit(reg_h, MAX_ROWS);
            kw = fit(reg_kw, MAXK); kh = fit(reg_kh, MAXK); ch = fit(reg_ch, NCH);
            wk = kw / 2; hk = kh / 2;
            x = out_col; y = out_row;
            interior = x >= wk && x + wk < w && y >= hk && y + hk < h;
            for (int c = 0; c < 3; c++) begin
                val[c] = '0;
                if (c < ch) begin
                    if (interior) begin
                        acc = 0;
                        for (int i = 0; i < kh; i++) begin
                            slot = (out_slot + MAXK - hk + i) % MAXK;
                            for (int j = 0; j < kw; j++)
                                acc += longint'(coef[i*MAXK + j]) *
                                       longint'({1'b0, lines[slot][(x - wk + j) % MAXW][c]});
                        end
                        val[c] = rescale(acc);
                    end else begin
                        val[c] = {16'd0, lines[out_slot][x % MAXW][c]};
                    end
                end
            end
            r.c0 = val[0]; r.c1 = val[1]; r.c2 = val[2];
            r.last = (x + 1 >= w) && (y + 1 >= h);
            expected_pixels.push_back(r);
            if (pending > 0) pending--;
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_slot = (out_slot + 1) % MAXK;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
        endfunction

        // Note one accepted input transaction
        function void note_input(logic [CMD_W-1:0] cmd, logic [CIDX_W-1:0] idx,
                                 logic [COEF_W-1:0] cval, logic [PIX_W-1:0] p0,
                                 logic [PIX_W-1:0] p1, logic [PIX_W-1:0] p2);
            int unsigned w, h, lag;
            if (cmd == CMD_COEF) begin
                if (idx < MAXK*MAXK) coef[idx] = cval;
            end else if (cmd == CMD_PIXEL) begin
                w = fit(reg_w, MAXW); h = fit(reg_h, MAX_ROWS);
                lag = (fit(reg_kh, MAXK) / 2) * w + fit(reg_kw, MAXK) / 2;
                if (in_col >= w) in_col = 0;
                lines[in_slot][in_col % MAXW][0] = p0;
                lines[in_slot][in_col % MAXW][1] = p1;
                lines[in_slot][in_col % MAXW][2] = p2;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_slot = (in_slot + 1) % MAXK;
                    in_row++;
                    if (in_row >= h) in_row = 0;
                end
                pending++;
                if (pending > lag) produce();
            end else if (cmd == CMD_FLUSH) begin
                if (pending > 0) produce();
            end
        endfunction

        // Compare one output transaction with the oldest expectation
        function void check_result(logic signed [RES_W-1:0] c0, logic signed [RES_W-1:0] c1,
                                   logic signed [RES_W-1:0] c2, logic last);
            t_pixel_result e;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result c0=%0d c1=%0d c2=%0d last=%0b",
                         $realtime, c0, c1, c2, last);
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            if (c0 !== e.c0) begin
                $display("%0t: c0 expected %0d actual %0d", $realtime, e.c0, c0); errors++;
            end
            if (c1 !== e.c1) begin
                $display("%0t: c1 expected %0d actual %0d", $realtime, e.c1, c1); errors++;
            end
            if (c2 !== e.c2) begin
                $display("%0t: c2 expected %0d actual %0d", $realtime, e.c2, c2); errors++;
            end
            if (last !== e.last) begin
                $display("%0t: frame_last expected %0b actual %0b", $realtime, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall;
    logic [CMD_W-1:0] i_cmd;
    logic [CIDX_W-1:0] i_coef_index;
    logic signed [COEF_W-1:0] i_coef_value;
    logic [PIX_W-1:0] i_pix_c0, i_pix_c1, i_pix_c2;
    logic o_out_valid, i_out_stall;
    logic signed [RES_W-1:0] o_out_c0, o_out_c1, o_out_c2;
    logic o_frame_last;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    conv_scoreboard sb = new();
    bit send_idle_on = 1;
    int items_sent = 0;
    int quiet_cycles = 0;

    image_kernel_convolution_core uut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: stall a random number of cycles before each result, none in every third run of 64 results
    int stall_left = 0;
    int results_seen = 0;
    int results_handled = 0;
    always @(negedge i_clk) begin
        if (results_handled != results_seen) begin
            results_handled = results_seen;
            stall_left = ((results_seen / 64) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_c0, o_out_c1, o_out_c2, o_frame_last);
            results_seen++;
        end
    end

    // Watchdog: end the run after a long stretch with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [CIDX_W-1:0] idx,
                             logic [COEF_W-1:0] cval, logic [PIX_W-1:0] p0,
                             logic [PIX_W-1:0] p1, logic [PIX_W-1:0] p2);
        int gap;
        gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_coef_index <= idx;
        i_coef_value <= cval;
        i_pix_c0 <= p0;
        i_pix_c1 <= p1;
        i_pix_c2 <= p2;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(cmd, idx, cval, p0, p1, p2);
        if (cmd != CMD_RESERVED && !(cmd == CMD_COEF && idx >= MAXK*MAXK)) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                              logic [PIX_W-1:0] p2);
        send_item(CMD_PIXEL, CIDX_W'($urandom_range(0, 63)),
                  COEF_W'($urandom_range(0, 65535)), p0, p1, p2);
    endtask

    task automatic send_coef(int idx, logic [COEF_W-1:0] cval);
        send_item(CMD_COEF, CIDX_W'(idx), cval, PIX_W'($urandom_range(0, 65535)),
                  PIX_W'($urandom_range(0, 65535)), PIX_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_noise();
        send_item($urandom_range(0, 1) ? CMD_RESERVED : CMD_COEF,
                  CIDX_W'($urandom_range(49, 63)), COEF_W'($urandom_range(0, 65535)),
                  PIX_W'($urandom_range(0, 65535)), PIX_W'($urandom_range(0, 65535)),
                  PIX_W'($urandom_range(0, 65535)));
    endtask

    // Drain pending pixels, then hold until every result is in and the core settles
    task automatic finish_frame();
        while (sb.pending > 0) send_pixel_flush();
        i_in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_pixel_flush();
        send_item(CMD_FLUSH, CIDX_W'($urandom_range(0, 63)), COEF_W'($urandom_range(0, 65535)),
                  PIX_W'($urandom_range(0, 65535)), PIX_W'($urandom_range(0, 65535)),
                  PIX_W'($urandom_range(0, 65535)));
    endtask

    task automatic configure(int w, int h, int kw, int kh, int ch);
        logic [CFG_IDX_W-1:0] idx[5];
        int data[5];
        idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KERNEL_WIDTH, REG_KERNEL_HEIGHT,
                REG_CHANNELS_USED};
        data = '{w, h, kw, kh, ch};
        for (int r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data <= CFG_DAT_W'(data[r]);
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[r], CFG_DAT_W'(data[r]));
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase: new geometry, some new coefficients, one or two frames
    task automatic random_phase(int w, int h, int kw, int kh, int ch, int frames);
        int n;
        configure(w, h, kw, kh, ch);
        send_idle_on = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 3) == 0) send_pixel_flush();
        n = $urandom_range(4, 16);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_coef($urandom_range(0, 48), COEF_W'($urandom_range(0, 65535)));
        end
        n = sb.fit(w, MAXW) * sb.fit(h, MAX_ROWS) * frames;
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            send_pixel(PIX_W'($urandom_range(0, 65535)), PIX_W'($urandom_range(0, 65535)),
                       PIX_W'($urandom_range(0, 65535)));
        end
        finish_frame();
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_cmd = CMD_COEF;
        i_coef_index = '0;
        i_coef_value = '0;
        i_pix_c0 = '0;
        i_pix_c1 = '0;
        i_pix_c2 = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: coefficient extremes, ignored indexes, reserved command, empty flush
        configure(4, 4, 3, 3, 3);
        send_pixel_flush();
        send_coef(0, 16'h8000);
        send_coef(1, 16'h7FFF);
        send_coef(2, 16'h1000);
        send_coef(7, 16'hFFFF);
        send_coef(8, 16'h0800);
        send_coef(48, 16'h7FFF);
        send_coef(49, 16'h1234);
        send_coef(63, 16'h4321);
        send_item(CMD_RESERVED, 6'd0, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int p = 0; p < 16; p++) begin
            if (p % 3 == 0) send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
            else if (p % 3 == 1) send_pixel(16'h0000, 16'hFFFF, 16'h8000);
            else send_pixel(16'hFFFF, 16'hFFFF, 16'h0001);
        end
        finish_frame();

        // Register extremes: zero acts as one, narrow image
        random_phase(0, 0, 0, 0, 0, 2);
        random_phase(2, 3, 7, 7, 3, 2);
        random_phase(7, 7, 7, 7, 3, 1);
        random_phase(8, 6, 2, 4, 3, 2);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
            random_phase($urandom_range(0, 12), $urandom_range(0, 10), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(1, 2));

        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
